@@ rtl/core/dett_pkg.sv @@
// Shared types and constants for the deferred event timer table.
// No dependencies; every other file takes names from here by scope or by import.
package dett_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int NUM_W       = $clog2(TABLE_DEPTH + 1);

  localparam int DELAY_W    = 16;
  localparam int CODE_W     = 4;
  localparam int TARGET_W   = 8;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_EXPIRED   = 3'd3,
    ST_NONE      = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHUTDOWN = 2'd0,
    REG_HOLD     = 2'd1,
    REG_DEDUP    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              shutdown;
    logic              hold;
    logic [CODE_W-1:0] dedup_code;
  } cfg_t;

  typedef struct packed {
    logic                   valid;
    logic                   expired;
    logic [COUNT_WIDTH-1:0] count;
    logic [CODE_W-1:0]      code;
    logic [TARGET_W-1:0]    target;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_DEC,
    OP_SHIFT,
    OP_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [TARGET_W-1:0] probe_target;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_COUNT,
    S_PASS
  } ctrl_state_t;

  // Clamp an inserted delay to the countdown range.
  function automatic logic [COUNT_WIDTH-1:0] sat_delay(input logic [DELAY_W-1:0] d);
    logic [32:0] w;
    w = 33'(d);
    if (w > COUNT_MAX) w = COUNT_MAX;
    return w[COUNT_WIDTH-1:0];
  endfunction

endpackage

@@ rtl/core/dett_if.sv @@
// Valid/ready channel interfaces for command items and result items.
// Depends on dett_pkg for field widths.
interface dett_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [dett_pkg::DELAY_W-1:0]  delay_ticks;
  logic [dett_pkg::CODE_W-1:0]   event_code;
  logic [dett_pkg::TARGET_W-1:0] target_id;

  modport source(output valid, command, delay_ticks, event_code, target_id, input ready);
  modport sink(input valid, command, delay_ticks, event_code, target_id, output ready);
endinterface

interface dett_out_if;
  logic                          valid;
  logic                          ready;
  logic [dett_pkg::STATUS_W-1:0] status;
  logic [dett_pkg::CODE_W-1:0]   fired_event_code;
  logic [dett_pkg::TARGET_W-1:0] fired_target_id;
  logic                          last_result;
  logic                          pending_nonempty;

  modport source(output valid, status, fired_event_code, fired_target_id, last_result,
                 pending_nonempty, input ready);
  modport sink(input valid, status, fired_event_code, fired_target_id, last_result,
               pending_nonempty, output ready);
endinterface

@@ rtl/core/dett_cell.sv @@
// One timer cell: holds an entry, decrements it, loads it or shifts from its upper neighbor.
// Depends on dett_pkg.
module dett_cell (
  input  logic                clk,
  input  logic                rst,
  input  dett_pkg::cell_ctl_t ctl,
  input  logic                sel,
  input  dett_pkg::entry_t    load,
  input  dett_pkg::entry_t    nbr,
  output dett_pkg::entry_t    q,
  output logic                hit
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid   <= 1'b0;
      q.expired <= 1'b0;
    end else begin
      case (ctl.op)
        dett_pkg::OP_DEC: begin
          if (q.valid) begin
            q.count   <= q.count - 1'b1;
            q.expired <= (q.count == dett_pkg::COUNT_WIDTH'(1));
          end
        end
        dett_pkg::OP_SHIFT: begin
          q <= sel ? load : nbr;
        end
        dett_pkg::OP_INSERT: begin
          if (sel) q <= load;
        end
        default: ;
      endcase
    end
  end

  assign hit = q.valid && (q.target == ctl.probe_target);

endmodule

@@ rtl/core/dett_ctrl.sv @@
// Sequencer for the timer chain: command decode, insert, tick pass, result register.
// Depends on dett_pkg and the channel interfaces in dett_if.
module dett_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  dett_in_if.sink                             in_ch,
  dett_out_if.source                          out_ch,
  input  dett_pkg::cfg_t                      cfg,
  input  dett_pkg::entry_t                    head,
  input  logic [dett_pkg::TABLE_DEPTH-1:0]    hit_vec,
  input  logic [dett_pkg::TABLE_DEPTH-1:0]    exp_vec,
  output dett_pkg::cell_ctl_t                 ctl,
  output logic [dett_pkg::TABLE_DEPTH-1:0]    sel,
  output dett_pkg::entry_t                    load
);

  localparam int D  = dett_pkg::TABLE_DEPTH;
  localparam int NW = dett_pkg::NUM_W;
  localparam int IW = dett_pkg::IDX_W;

  dett_pkg::ctrl_state_t state, state_next;

  logic                          cmd_tick;
  logic [dett_pkg::DELAY_W-1:0]  c_delay;
  logic [dett_pkg::CODE_W-1:0]   c_code;
  logic [dett_pkg::TARGET_W-1:0] c_target;

  logic [NW-1:0] n;         // pending entries, packed from cell 0 upward
  logic [NW-1:0] rem;       // entries still to pass the head
  logic [NW-1:0] exp_left;  // expired results still to deliver
  logic [IW-1:0] wr;        // cell that takes the next survivor
  logic          pend;

  logic                          o_valid;
  dett_pkg::status_t             o_status;
  logic [dett_pkg::CODE_W-1:0]   o_code;
  logic [dett_pkg::TARGET_W-1:0] o_target;
  logic                          o_last;
  logic                          o_pend;

  logic                          slot_free, ignore, dup, full, head_fire, step;
  logic [NW-1:0]                 exp_cnt;
  dett_pkg::status_t             ins_status;
  logic                          emit, e_last, e_pend;
  dett_pkg::status_t             e_status;
  logic [dett_pkg::CODE_W-1:0]   e_code;
  logic [dett_pkg::TARGET_W-1:0] e_target;

  assign slot_free = !o_valid || out_ch.ready;
  assign ignore    = cfg.shutdown || (cmd_tick && cfg.hold);
  assign dup       = (c_code == cfg.dedup_code) && (|hit_vec);
  assign full      = (n == NW'(D));
  assign exp_cnt   = NW'($countones(exp_vec));
  assign head_fire = head.expired;
  assign step      = !head_fire || slot_free;

  always_comb begin
    if (dup)       ins_status = dett_pkg::ST_DUPLICATE;
    else if (full) ins_status = dett_pkg::ST_FULL;
    else           ins_status = dett_pkg::ST_ACCEPTED;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dett_pkg::S_IDLE: begin
        if (in_ch.valid) state_next = dett_pkg::S_EXEC;
      end
      dett_pkg::S_EXEC: begin
        if (ignore || !cmd_tick) begin
          if (slot_free) state_next = dett_pkg::S_IDLE;
        end else begin
          state_next = dett_pkg::S_COUNT;
        end
      end
      dett_pkg::S_COUNT: begin
        if (exp_cnt == '0) begin
          if (slot_free) state_next = dett_pkg::S_IDLE;
        end else begin
          state_next = dett_pkg::S_PASS;
        end
      end
      dett_pkg::S_PASS: begin
        if (step && rem == NW'(1)) state_next = dett_pkg::S_IDLE;
      end
      default: state_next = dett_pkg::S_IDLE;
    endcase
  end

  // outputs to the chain and to the result register
  always_comb begin
    ctl.op           = dett_pkg::OP_HOLD;
    ctl.probe_target = c_target;
    sel              = '0;
    load             = head;
    load.expired     = 1'b0;
    emit             = 1'b0;
    e_status         = dett_pkg::ST_NONE;
    e_code           = '0;
    e_target         = '0;
    e_last           = 1'b1;
    e_pend           = (n != '0);
    case (state)
      dett_pkg::S_EXEC: begin
        if (ignore) begin
          emit = slot_free;
        end else if (!cmd_tick) begin
          emit     = slot_free;
          e_status = ins_status;
          if (ins_status == dett_pkg::ST_ACCEPTED) begin
            e_pend = 1'b1;
            if (slot_free) begin
              ctl.op       = dett_pkg::OP_INSERT;
              sel          = D'(1) << n[IW-1:0];
              load.valid   = 1'b1;
              load.expired = 1'b0;
              load.count   = dett_pkg::sat_delay(c_delay);
              load.code    = c_code;
              load.target  = c_target;
            end
          end
        end else begin
          ctl.op = dett_pkg::OP_DEC;
        end
      end
      dett_pkg::S_COUNT: begin
        if (exp_cnt == '0) emit = slot_free;
      end
      dett_pkg::S_PASS: begin
        if (step) begin
          ctl.op = dett_pkg::OP_SHIFT;
          if (!head_fire) begin
            sel = D'(1) << wr;
          end else begin
            emit     = 1'b1;
            e_status = dett_pkg::ST_EXPIRED;
            e_code   = head.code;
            e_target = head.target;
            e_last   = (exp_left == NW'(1));
            e_pend   = pend;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= dett_pkg::S_IDLE;
      n       <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) o_valid <= 1'b1;
      else if (out_ch.ready) o_valid <= 1'b0;
      case (state)
        dett_pkg::S_EXEC: begin
          if (!ignore && !cmd_tick && slot_free && ins_status == dett_pkg::ST_ACCEPTED)
            n <= n + 1'b1;
        end
        dett_pkg::S_PASS: begin
          if (step && head_fire) n <= n - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == dett_pkg::S_IDLE && in_ch.valid) begin
      cmd_tick <= in_ch.command;
      c_delay  <= in_ch.delay_ticks;
      c_code   <= in_ch.event_code;
      c_target <= in_ch.target_id;
    end
    if (state == dett_pkg::S_COUNT) begin
      exp_left <= exp_cnt;
      rem      <= n;
      wr       <= IW'(n - NW'(1));
      pend     <= (n != exp_cnt);
    end
    if (state == dett_pkg::S_PASS && step) begin
      rem <= rem - 1'b1;
      if (head_fire) begin
        exp_left <= exp_left - 1'b1;
        wr       <= wr - 1'b1;
      end
    end
    if (emit) begin
      o_status <= e_status;
      o_code   <= e_code;
      o_target <= e_target;
      o_last   <= e_last;
      o_pend   <= e_pend;
    end
  end

  assign in_ch.ready             = (state == dett_pkg::S_IDLE);
  assign out_ch.valid            = o_valid;
  assign out_ch.status           = o_status;
  assign out_ch.fired_event_code = o_code;
  assign out_ch.fired_target_id  = o_target;
  assign out_ch.last_result      = o_last;
  assign out_ch.pending_nonempty = o_pend;

endmodule

@@ rtl/core/deferred_event_timer_table.sv @@
// Top level of the deferred event timer table: config registers, cell chain, sequencer.
// Depends on dett_pkg, dett_if, dett_cell and dett_ctrl.
//
// Pending events live in a chain of cells kept in insertion order, oldest in cell 0.
// An insert or an ignored command runs in an execute state that registers its result.
// A tick decrements every cell in the execute state and counts the expired entries in a
// count state, which registers the result when nothing expires; otherwise the chain
// shifts every pending entry past the head, one per cycle, delivering expired
// entries oldest first and packing survivors back in order. A stalled result output
// holds the pass on an expiring entry. One item is in work at a time; the next is
// taken once the previous result is in the output register.
module deferred_event_timer_table (
  input  logic                              clk,
  input  logic                              rst,
  dett_in_if.sink                           in_ch,
  dett_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [dett_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [dett_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int D = dett_pkg::TABLE_DEPTH;

  dett_pkg::cfg_t      cfg;
  dett_pkg::cell_ctl_t ctl;
  dett_pkg::entry_t    load;
  dett_pkg::entry_t    cell_q [D];
  logic [D-1:0]        sel, hit_vec, exp_vec, vld_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shutdown   <= 1'b0;
      cfg.hold       <= 1'b0;
      cfg.dedup_code <= '1;
    end else if (cfg_we) begin
      if (cfg_idx == dett_pkg::REG_SHUTDOWN) cfg.shutdown <= cfg_data[0];
      if (cfg_idx == dett_pkg::REG_HOLD) cfg.hold <= cfg_data[0];
      if (cfg_idx == dett_pkg::REG_DEDUP) cfg.dedup_code <= cfg_data[dett_pkg::CODE_W-1:0];
    end
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    dett_pkg::entry_t nbr;
    if (i == D - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    dett_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .sel  (sel[i]),
      .load (load),
      .nbr  (nbr),
      .q    (cell_q[i]),
      .hit  (hit_vec[i])
    );
    assign exp_vec[i] = cell_q[i].expired;
    assign vld_vec[i] = cell_q[i].valid;
  end

  dett_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg     (cfg),
    .head    (cell_q[0]),
    .hit_vec (hit_vec),
    .exp_vec (exp_vec),
    .ctl     (ctl),
    .sel     (sel),
    .load    (load)
  );

  // pending entries always sit packed from cell 0 upward, also mid-pass
  a_packed: assert property (@(posedge clk) disable iff (rst)
    ((vld_vec >> 1) & ~vld_vec) == '0)
    else $error("hole in the pending chain");

  a_exp_valid: assert property (@(posedge clk) disable iff (rst)
    (exp_vec & ~vld_vec) == '0)
    else $error("expired mark on an empty cell");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.status != dett_pkg::ST_EXPIRED) |-> out_ch.last_result)
    else $error("single result transaction without last mark");

  a_no_accept_mid_pass: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == dett_pkg::OP_SHIFT) |-> !in_ch.ready)
    else $error("input taken while the chain is shifting");

endmodule

@@ tb/sv/tb_deferred_event_timer_table.sv @@
// Self-checking testbench for deferred_event_timer_table: directed and random commands
// against a queue-based predictor kept in a small scoreboard class.
// Depends on dett_pkg, dett_if and the deferred_event_timer_table RTL.
module tb_deferred_event_timer_table;
  timeunit 1ns;
  timeprecision 1ps;

  import dett_pkg::*;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct {
    logic                command;
    logic [DELAY_W-1:0]  delay;
    logic [CODE_W-1:0]   code;
    logic [TARGET_W-1:0] target;
  } timer_cmd_t;

  typedef struct {
    logic [COUNT_WIDTH-1:0] remaining;
    logic [CODE_W-1:0]      code;
    logic [TARGET_W-1:0]    target;
  } timer_entry_t;

  typedef struct packed {
    status_t             status;
    logic [CODE_W-1:0]   code;
    logic [TARGET_W-1:0] target;
    logic                last;
    logic                nonempty;
  } timer_result_t;

  class timer_table_scoreboard;
    timer_entry_t  timers_q[$];    // pending events, oldest first
    timer_result_t expected_q[$];
    logic          shutdown;
    logic          hold;
    logic [CODE_W-1:0] dedup_code;
    int            errors;

    function new();
      shutdown   = 1'b0;
      hold       = 1'b0;
      dedup_code = '1;
      errors     = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SHUTDOWN: shutdown = data[0];
        REG_HOLD:     hold = data[0];
        REG_DEDUP:    dedup_code = data[CODE_W-1:0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void add_result(status_t st, logic [CODE_W-1:0] code,
                             logic [TARGET_W-1:0] target, logic last);
      timer_result_t r;
      r.status   = st;
      r.code     = code;
      r.target   = target;
      r.last     = last;
      r.nonempty = (timers_q.size() != 0);
      expected_q.push_back(r);
    endfunction

    function void note_command(timer_cmd_t c);
      timer_entry_t survivors[$];
      timer_entry_t fired[$];
      timer_entry_t e;
      status_t      st;
      logic [32:0]  wide;
      if (shutdown || (c.command == CMD_TICK && hold)) begin
        add_result(ST_NONE, '0, '0, 1'b1);
        return;
      end
      if (c.command == CMD_TICK) begin
        // a zero countdown wraps to the top and keeps waiting
        foreach (timers_q[i]) begin
          e = timers_q[i];
          e.remaining = e.remaining - 1'b1;
          if (e.remaining == '0) fired.push_back(e);
          else survivors.push_back(e);
        end
        timers_q = survivors;
        if (fired.size() == 0) begin
          add_result(ST_NONE, '0, '0, 1'b1);
        end else begin
          foreach (fired[i])
            add_result(ST_EXPIRED, fired[i].code, fired[i].target, i == fired.size() - 1);
        end
        return;
      end
      st = ST_ACCEPTED;
      // duplicate check wins over table full
      if (c.code == dedup_code) begin
        foreach (timers_q[i])
          if (timers_q[i].target == c.target) st = ST_DUPLICATE;
      end
      if (st == ST_ACCEPTED && timers_q.size() >= TABLE_DEPTH) st = ST_FULL;
      if (st == ST_ACCEPTED) begin
        wide = 33'(c.delay);
        if (wide > (33'd1 << COUNT_WIDTH) - 33'd1) wide = (33'd1 << COUNT_WIDTH) - 33'd1;
        e.remaining = wide[COUNT_WIDTH-1:0];
        e.code      = c.code;
        e.target    = c.target;
        timers_q.push_back(e);
      end
      add_result(st, '0, '0, 1'b1);
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result status %0d code %0d target %0d", $time,
                 got.status, got.code, got.target);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status expected %0d got %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.code !== exp.code) begin
        $display("%0t: fired_event_code expected %0d got %0d", $time, exp.code, got.code);
        errors++;
      end
      if (got.target !== exp.target) begin
        $display("%0t: fired_target_id expected %0d got %0d", $time, exp.target, got.target);
        errors++;
      end
      if (got.last !== exp.last) begin
        $display("%0t: last_result expected %0b got %0b", $time, exp.last, got.last);
        errors++;
      end
      if (got.nonempty !== exp.nonempty) begin
        $display("%0t: pending_nonempty expected %0b got %0b", $time, exp.nonempty,
                 got.nonempty);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  dett_in_if  in_ch();
  dett_out_if out_ch();

  deferred_event_timer_table dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  timer_table_scoreboard sb = new();

  bit tx_idle_en;
  bit rx_idle_en;
  bit long_stall_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (299) @(negedge clk);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : sample_result
    timer_result_t got;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.status   = status_t'(out_ch.status);
      got.code     = out_ch.fired_event_code;
      got.target   = out_ch.fired_target_id;
      got.last     = out_ch.last_result;
      got.nonempty = out_ch.pending_nonempty;
      sb.check_result(got);
    end
  end

  function automatic timer_cmd_t make_cmd(logic command, logic [DELAY_W-1:0] delay,
                                          logic [CODE_W-1:0] code,
                                          logic [TARGET_W-1:0] target);
    timer_cmd_t c;
    c.command = command;
    c.delay   = delay;
    c.code    = code;
    c.target  = target;
    return c;
  endfunction

  // mostly short delays so entries expire; ticks carry random junk fields
  function automatic timer_cmd_t random_cmd(int tick_pct);
    timer_cmd_t c;
    int pick;
    c.command = ($urandom_range(0, 99) < tick_pct) ? CMD_TICK : CMD_INSERT;
    c.delay   = DELAY_W'($urandom);
    c.code    = CODE_W'($urandom);
    c.target  = TARGET_W'($urandom);
    if (c.command == CMD_INSERT) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) c.delay = DELAY_W'($urandom_range(1, 8));
      else if (pick < 95) c.delay = DELAY_W'($urandom_range(9, 40));
      else c.delay = DELAY_W'($urandom_range(100, 300));
      if ($urandom_range(0, 99) < 40) c.code = sb.dedup_code;
      if ($urandom_range(0, 99) < 60) c.target = TARGET_W'($urandom_range(0, 7));
    end
    return c;
  endfunction

  task automatic send_cmd(timer_cmd_t c);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.command     <= c.command;
    in_ch.delay_ticks <= c.delay;
    in_ch.event_code  <= c.code;
    in_ch.target_id   <= c.target;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_command(c);
  endtask

  task automatic send_random(int count, int tick_pct);
    repeat (count) send_cmd(random_cmd(tick_pct));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // upper data bits are don't-care for the one-bit registers
  task automatic program_regs(logic shutdown, logic hold, logic [CODE_W-1:0] dedup);
    logic [CFG_DATA_W-2:0] junk;
    junk = (CFG_DATA_W-1)'($urandom);
    write_reg(REG_SHUTDOWN, {junk, shutdown});
    junk = (CFG_DATA_W-1)'($urandom);
    write_reg(REG_HOLD, {junk, hold});
    write_reg(REG_DEDUP, CFG_DATA_W'(dedup));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CODE_W-1:0] other_code;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_INSERT;
    in_ch.delay_ticks <= '0;
    in_ch.event_code  <= '0;
    in_ch.target_id   <= '0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    long_stall_req = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty tick, single expiry, zero and max delay, dedup hits
    send_cmd(make_cmd(CMD_TICK, 16'hFFFF, 4'hF, 8'hFF));
    send_cmd(make_cmd(CMD_INSERT, 16'd1, 4'd0, 8'd0));
    send_cmd(make_cmd(CMD_TICK, 16'd0, 4'd0, 8'd0));
    send_cmd(make_cmd(CMD_INSERT, 16'd0, 4'd5, 8'hFF));
    send_cmd(make_cmd(CMD_INSERT, 16'hFFFF, 4'd10, 8'h80));
    send_cmd(make_cmd(CMD_INSERT, 16'd2, 4'd15, 8'h80));
    send_cmd(make_cmd(CMD_INSERT, 16'd2, 4'd15, 8'h01));
    send_cmd(make_cmd(CMD_INSERT, 16'd2, 4'd3, 8'h01));
    send_cmd(make_cmd(CMD_INSERT, 16'd1, 4'd15, 8'h01));
    send_cmd(make_cmd(CMD_INSERT, 16'd1, 4'd15, 8'h02));
    send_cmd(make_cmd(CMD_TICK, 16'h5A5A, 4'd9, 8'h33));
    send_cmd(make_cmd(CMD_TICK, 16'hA5A5, 4'd6, 8'hCC));
    send_cmd(make_cmd(CMD_TICK, 16'd7, 4'd1, 8'd4));
    wait_drained();

    program_regs(1'b0, 1'b0, 4'd0);
    send_random(130, 45);
    wait_drained();

    // fill the table while results are held off, then a duplicate into a full table
    other_code = sb.dedup_code + 1'b1;
    long_stall_req = 1'b1;
    for (int i = 0; i < 20; i++)
      send_cmd(make_cmd(CMD_INSERT, 16'($urandom_range(2, 10)), other_code, 8'(8'h40 + i)));
    send_cmd(make_cmd(CMD_INSERT, 16'd3, sb.dedup_code, 8'h40));
    send_random(25, 100);
    wait_drained();

    program_regs(1'b0, 1'b1, 4'd15);
    send_random(50, 45);
    wait_drained();

    program_regs(1'b0, 1'b0, 4'd7);
    send_random(30, 70);
    wait_drained();

    program_regs(1'b1, 1'b1, 4'd0);
    send_random(20, 45);
    wait_drained();

    // last stretch runs without idling on either side
    program_regs(1'b0, 1'b0, 4'($urandom));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random(180, 45);
    wait_drained();
    repeat (20) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tb_deferred_event_timer_table passed");
    end else begin
      $display("tb_deferred_event_timer_table failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_deferred_event_timer_table failed");
    $finish;
  end

endmodule

@@ deferred_event_timer_table.f @@
rtl/core/dett_pkg.sv
rtl/core/dett_if.sv
rtl/core/dett_cell.sv
rtl/core/dett_ctrl.sv
rtl/core/deferred_event_timer_table.sv
tb/sv/tb_deferred_event_timer_table.sv
